FILE: hw/rtl/sdrs_pkg.sv
// ----------------------------------------------------------------------------
// SCAN disk request scheduler package
// Shared widths, register indexes, chain commands and cell types.
// ----------------------------------------------------------------------------
package sdrs_pkg;

    localparam int MAX_REQ   = 32;
    localparam int CYL_W     = 16;
    localparam int CNT_W     = $clog2(MAX_REQ + 1);
    localparam int TOTAL_W   = 22;
    localparam int CFG_IDX_W = 1;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX   = {TOTAL_W{1'b1}};
    localparam logic [CYL_W-1:0]   END_CYL_RST = {CYL_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_END_CYL   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_POS = 1'd1;

    typedef enum logic [2:0] {
        OP_HOLD     = 3'd0,
        OP_INSERT   = 3'd1,
        OP_ROTATE   = 3'd2,
        OP_POP_LOW  = 3'd3,
        OP_SHIFT_UP = 3'd4
    } t_chain_op;

    typedef struct packed {
        t_chain_op        op;
        logic [CYL_W-1:0] cyl;
    } t_chain_cmd;

    typedef struct packed {
        logic             v;
        logic [CYL_W-1:0] val;
    } t_cell;

    typedef struct packed {
        t_cell c;
        logic  gt;
        logic  fill_ok;
    } t_dn_link;

    localparam t_cell CELL_EMPTY = '{v: 1'b0, val: '0};

endpackage

FILE: hw/rtl/sdrs_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Carries one cylinder request per transaction with a last-of-batch flag.
// ----------------------------------------------------------------------------
interface sdrs_req_if;
    import sdrs_pkg::*;

    logic             valid;
    logic             ready;
    logic [CYL_W-1:0] request_cylinder;
    logic             batch_end;

    modport source (output valid, output request_cylinder, output batch_end, input ready);
    modport sink (input valid, input request_cylinder, input batch_end, output ready);

endinterface

FILE: hw/rtl/sdrs_move_if.sv
// ----------------------------------------------------------------------------
// Move channel
// Carries one head move of the service order per transaction.
// ----------------------------------------------------------------------------
interface sdrs_move_if;
    import sdrs_pkg::*;

    logic               valid;
    logic               ready;
    logic [CYL_W-1:0]   move_from;
    logic [CYL_W-1:0]   move_to;
    logic [CYL_W-1:0]   move_distance;
    logic [TOTAL_W-1:0] running_total;
    logic [CNT_W-1:0]   request_total;
    logic               final_move;

    modport source (
        output valid, output move_from, output move_to, output move_distance,
        output running_total, output request_total, output final_move,
        input ready
    );
    modport sink (
        input valid, input move_from, input move_to, input move_distance,
        input running_total, input request_total, input final_move,
        output ready
    );

endinterface

FILE: hw/rtl/sdrs_cell.sv
// ----------------------------------------------------------------------------
// Sorting chain cell
// Holds one request and takes part in sorted insertion, rotation and shifts.
// ----------------------------------------------------------------------------
module sdrs_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sdrs_pkg::t_chain_cmd i_cmd,
    input  sdrs_pkg::t_dn_link   i_dn,
    input  sdrs_pkg::t_cell      i_up,
    output sdrs_pkg::t_cell      o_cell,
    output logic                 o_gt
);
    import sdrs_pkg::*;

    logic             r_v;
    logic [CYL_W-1:0] r_val;
    logic             n_v;
    logic [CYL_W-1:0] n_val;

    assign o_gt   = r_v && (r_val > i_cmd.cyl);
    assign o_cell = '{v: r_v, val: r_val};

    always_comb begin
        n_v   = r_v;
        n_val = r_val;
        case (i_cmd.op)
            OP_INSERT: begin
                if (i_dn.gt) begin
                    n_v   = i_dn.c.v;
                    n_val = i_dn.c.val;
                end else if (o_gt || (!r_v && i_dn.fill_ok)) begin
                    n_v   = 1'b1;
                    n_val = i_cmd.cyl;
                end
            end
            OP_ROTATE, OP_POP_LOW: begin
                n_v   = i_up.v;
                n_val = i_up.val;
            end
            OP_SHIFT_UP: begin
                n_v   = i_dn.c.v;
                n_val = i_dn.c.val;
            end
            default: begin
                n_v   = r_v;
                n_val = r_val;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

FILE: hw/rtl/sdrs_chain.sv
// ----------------------------------------------------------------------------
// Sorting chain
// A row of cells kept in ascending order, with taps at both ends.
// ----------------------------------------------------------------------------
module sdrs_chain (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sdrs_pkg::t_chain_cmd i_cmd,
    output sdrs_pkg::t_cell      o_low,
    output sdrs_pkg::t_cell      o_top,
    output logic                 o_any,
    output logic                 o_full
);
    import sdrs_pkg::*;

    t_cell    w_cell [MAX_REQ];
    logic     w_gt   [MAX_REQ];
    t_dn_link w_dn   [MAX_REQ];
    t_cell    w_up   [MAX_REQ];
    logic [MAX_REQ-1:0] w_valid;

    genvar g;
    generate
        for (g = 0; g < MAX_REQ; g++) begin : g_cell
            if (g == 0) begin : g_first
                assign w_dn[g] = '{c: CELL_EMPTY, gt: 1'b0, fill_ok: 1'b1};
            end else begin : g_rest
                assign w_dn[g] = '{c: w_cell[g-1], gt: w_gt[g-1], fill_ok: w_cell[g-1].v};
            end
            if (g == MAX_REQ - 1) begin : g_last
                assign w_up[g] = (i_cmd.op == OP_ROTATE) ? w_cell[0] : CELL_EMPTY;
            end else begin : g_inner
                assign w_up[g] = w_cell[g+1];
            end
            assign w_valid[g] = w_cell[g].v;

            sdrs_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_cmd   (i_cmd),
                .i_dn    (w_dn[g]),
                .i_up    (w_up[g]),
                .o_cell  (w_cell[g]),
                .o_gt    (w_gt[g])
            );
        end
    endgenerate

    assign o_low  = w_cell[0];
    assign o_top  = w_cell[MAX_REQ-1];
    assign o_any  = |w_valid;
    assign o_full = w_cell[MAX_REQ-1].v;

endmodule

FILE: hw/rtl/scan_disk_request_scheduler_core.sv
// ----------------------------------------------------------------------------
// SCAN disk request scheduler
// Sorts a batch of cylinder requests and emits the elevator service order.
// ----------------------------------------------------------------------------
// Requests are taken one per cycle into a sorted chain of MAX_REQ cells; a
// request that arrives while the chain is full is dropped. The transaction
// with batch_end set starts the sweep, during which no request is taken. The
// sweep first rotates the chain once for each held request below the start
// position, then emits one move per cycle for the upper requests while the
// move channel takes each move, then the move to the end cylinder, then
// shifts the chain up one cell per cycle, held while a move waits on the
// channel, emitting a move whenever the top cell holds a request, and ends
// with the move to cylinder 0. With n requests held the sweep gives n + 2 moves.
module scan_disk_request_scheduler_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sdrs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sdrs_pkg::CYL_W-1:0]     i_cfg_data,
    sdrs_req_if.sink                       i_req,
    sdrs_move_if.source                    o_move
);
    import sdrs_pkg::*;

    typedef enum logic [5:0] {
        S_LOAD = 6'b000001,
        S_ROT  = 6'b000010,
        S_UP   = 6'b000100,
        S_END  = 6'b001000,
        S_DOWN = 6'b010000,
        S_ZERO = 6'b100000
    } t_state;

    t_state             r_state, n_state;
    logic [CYL_W-1:0]   r_end_cyl, r_start;
    logic [CNT_W-1:0]   r_held, n_held;
    logic [CNT_W-1:0]   r_rot, n_rot;
    logic [CYL_W-1:0]   r_head, n_head;
    logic [TOTAL_W-1:0] r_seek, n_seek;

    logic               r_out_valid;
    logic [CYL_W-1:0]   r_out_from, r_out_to, r_out_dist;
    logic [TOTAL_W-1:0] r_out_total;
    logic [CNT_W-1:0]   r_out_reqs;
    logic               r_out_final;

    t_chain_cmd       w_cmd;
    t_cell            w_low, w_top;
    logic             w_any, w_full;
    logic             w_adv, w_in_acc, w_below;
    logic             w_emit, w_final;
    logic [CYL_W-1:0] w_to, w_dist;
    logic [TOTAL_W:0] w_sum;

    sdrs_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_low   (w_low),
        .o_top   (w_top),
        .o_any   (w_any),
        .o_full  (w_full)
    );

    assign i_req.ready = (r_state == S_LOAD);
    assign w_in_acc    = i_req.valid && i_req.ready;
    assign w_adv       = !r_out_valid || o_move.ready;
    assign w_below     = w_low.val < r_start;

    always_comb begin
        n_state   = r_state;
        n_held    = r_held;
        n_rot     = r_rot;
        n_head    = r_head;
        n_seek    = r_seek;
        w_cmd.op  = OP_HOLD;
        w_cmd.cyl = i_req.request_cylinder;
        w_emit    = 1'b0;
        w_final   = 1'b0;
        w_to      = '0;
        case (r_state)
            S_LOAD: begin
                if (w_in_acc) begin
                    if (!w_full) begin
                        w_cmd.op = OP_INSERT;
                        n_held   = r_held + 1'b1;
                    end
                    if (i_req.batch_end) begin
                        n_state = S_ROT;
                        n_rot   = '0;
                        n_head  = r_start;
                        n_seek  = '0;
                    end
                end
            end
            S_ROT: begin
                if (!w_low.v || !w_below || (r_rot == r_held)) begin
                    n_state = S_UP;
                end else begin
                    w_cmd.op = OP_ROTATE;
                    n_rot    = r_rot + 1'b1;
                end
            end
            S_UP: begin
                if (w_low.v && !w_below) begin
                    if (w_adv) begin
                        w_cmd.op = OP_POP_LOW;
                        w_emit   = 1'b1;
                        w_to     = w_low.val;
                    end
                end else begin
                    n_state = S_END;
                end
            end
            S_END: begin
                if (w_adv) begin
                    w_emit  = 1'b1;
                    w_to    = r_end_cyl;
                    n_state = S_DOWN;
                end
            end
            S_DOWN: begin
                if (!w_any) begin
                    n_state = S_ZERO;
                end else if (!w_top.v) begin
                    w_cmd.op = OP_SHIFT_UP;
                end else if (w_adv) begin
                    w_cmd.op = OP_SHIFT_UP;
                    w_emit   = 1'b1;
                    w_to     = w_top.val;
                end
            end
            S_ZERO: begin
                if (w_adv) begin
                    w_emit  = 1'b1;
                    w_final = 1'b1;
                    w_to    = '0;
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase

        w_dist = (w_to >= r_head) ? (w_to - r_head) : (r_head - w_to);
        w_sum  = {1'b0, r_seek} + {{(TOTAL_W + 1 - CYL_W){1'b0}}, w_dist};
        if (w_emit) begin
            n_head = w_to;
            n_seek = (w_sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : w_sum[TOTAL_W-1:0];
        end
        if (w_final) begin
            n_held = '0;
            n_seek = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_end_cyl   <= END_CYL_RST;
            r_start     <= '0;
            r_held      <= '0;
            r_rot       <= '0;
            r_seek      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_held  <= n_held;
            r_rot   <= n_rot;
            r_seek  <= n_seek;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_END_CYL:   r_end_cyl <= i_cfg_data;
                    REG_START_POS: r_start   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_move.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_head <= n_head;
        if (w_emit) begin
            r_out_from  <= r_head;
            r_out_to    <= w_to;
            r_out_dist  <= w_dist;
            r_out_total <= n_seek == '0 && w_final ? 
                ((w_sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : w_sum[TOTAL_W-1:0]) :
                ((w_sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : w_sum[TOTAL_W-1:0]);
            r_out_reqs  <= w_final ? r_held : '0;
            r_out_final <= w_final;
        end
    end

    assign o_move.valid         = r_out_valid;
    assign o_move.move_from     = r_out_from;
    assign o_move.move_to       = r_out_to;
    assign o_move.move_distance = r_out_dist;
    assign o_move.running_total = r_out_total;
    assign o_move.request_total = r_out_reqs;
    assign o_move.final_move    = r_out_final;

`ifndef NO_ASSERTIONS
    a_clear_after_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_final) |=> (r_held == '0))
        else $error("held count not cleared after the final move");

    a_rot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROT) |-> (r_rot <= r_held))
        else $error("rotation count exceeds held count");

    a_total_on_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_move.valid && !o_move.final_move) |-> (o_move.request_total == '0))
        else $error("request total shown on a move that is not final");

    a_full_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |-> (w_full == (r_held == CNT_W'(MAX_REQ))))
        else $error("chain occupancy disagrees with held count");

    a_no_take_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_req.batch_end) |=> !i_req.ready)
        else $error("request taken during a sweep");
`endif

endmodule

FILE: tb/sv/scan_disk_request_scheduler_core_tb.sv
// ----------------------------------------------------------------------------
// SCAN disk request scheduler testbench
// Sends batches of cylinder requests under random stalls on both channels,
// predicts the elevator service order of every batch and checks each move
// transaction field by field, across several head and end cylinder settings.
// ----------------------------------------------------------------------------
module scan_disk_request_scheduler_core_tb;
    import sdrs_pkg::*;

    localparam int ITEMS      = 330;
    localparam int CFG_SETTLE = 8;
    localparam int TAIL       = 2 * MAX_REQ + 8;
    localparam int CALM_LO    = 140;
    localparam int CALM_HI    = 215;
    localparam int LIMIT_TIME = 12 * 400000;

    typedef struct packed {
        logic [CYL_W-1:0]   from_cyl;
        logic [CYL_W-1:0]   to_cyl;
        logic [CYL_W-1:0]   distance;
        logic [TOTAL_W-1:0] total;
        logic [CNT_W-1:0]   count;
        logic               fin;
    } t_move_rec;

    class scan_order_scoreboard;
        logic [CYL_W-1:0] held [MAX_REQ];
        int               held_n;
        logic [CYL_W-1:0] end_cyl;
        logic [CYL_W-1:0] start_pos;
        int unsigned      seek_sum;
        t_move_rec        expected_moves [$];
        int               errors;
        int               moves_checked;
        int               batches;
        int               requests;
        int               dropped;

        function new();
            end_cyl       = END_CYL_RST;
            start_pos     = '0;
            held_n        = 0;
            seek_sum      = 0;
            errors        = 0;
            moves_checked = 0;
            batches       = 0;
            requests      = 0;
            dropped       = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CYL_W-1:0] val);
            case (idx)
                REG_END_CYL: begin
                    end_cyl = val;
                end
                REG_START_POS: begin
                    start_pos = val;
                end
                default: begin
                end
            endcase
        endfunction

        function void add_move(logic [CYL_W-1:0] from_cyl, logic [CYL_W-1:0] to_cyl,
                               logic fin);
            t_move_rec   m;
            int unsigned d;
            d = (to_cyl >= from_cyl) ? to_cyl - from_cyl : from_cyl - to_cyl;
            seek_sum = (seek_sum + d > TOTAL_MAX) ? TOTAL_MAX : seek_sum + d;
            m.from_cyl = from_cyl;
            m.to_cyl   = to_cyl;
            m.distance = CYL_W'(d);
            m.total    = TOTAL_W'(seek_sum);
            m.count    = fin ? CNT_W'(held_n) : '0;
            m.fin      = fin;
            expected_moves.push_back(m);
        endfunction

        function void plan_sweep();
            int               split;
            int               i;
            logic [CYL_W-1:0] head;
            split = 0;
            while (split < held_n && held[split] < start_pos) split++;
            seek_sum = 0;
            head     = start_pos;
            for (i = split; i < held_n; i++) begin
                add_move(head, held[i], 1'b0);
                head = held[i];
            end
            add_move(head, end_cyl, 1'b0);
            head = end_cyl;
            for (i = split; i > 0; i--) begin
                add_move(head, held[i-1], 1'b0);
                head = held[i-1];
            end
            add_move(head, '0, 1'b1);
            held_n   = 0;
            seek_sum = 0;
            batches++;
        endfunction

        function void note_request(logic [CYL_W-1:0] cyl, logic last);
            int pos;
            requests++;
            if (held_n >= MAX_REQ) begin
                dropped++;
            end else begin
                pos = held_n;
                while (pos > 0 && held[pos-1] > cyl) begin
                    held[pos] = held[pos-1];
                    pos--;
                end
                held[pos] = cyl;
                held_n++;
            end
            if (last) plan_sweep();
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_move(t_move_rec got);
            t_move_rec want;
            if (expected_moves.size() == 0) begin
                $error("Unexpected move transaction from %0d to %0d.", got.from_cyl,
                       got.to_cyl);
                errors++;
                return;
            end
            want = expected_moves.pop_front();
            moves_checked++;
            compare_field("move_from", want.from_cyl, got.from_cyl);
            compare_field("move_to", want.to_cyl, got.to_cyl);
            compare_field("move_distance", want.distance, got.distance);
            compare_field("running_total", want.total, got.total);
            compare_field("request_total", want.count, got.count);
            compare_field("final_move", want.fin, got.fin);
        endfunction

        function int outstanding();
            return expected_moves.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CYL_W-1:0]     i_cfg_data;

    sdrs_req_if  req_ch ();
    sdrs_move_if move_ch ();

    scan_order_scoreboard sb = new();
    int items_sent = 0;
    int settings   = 0;

    scan_disk_request_scheduler_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req       (req_ch),
        .o_move      (move_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_TIME);
        $display("Verification failed");
        $finish;
    end

    function automatic bit in_calm_window();
        return items_sent >= CALM_LO && items_sent < CALM_HI;
    endfunction

    initial begin
        t_move_rec seen;
        move_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (move_ch.valid && move_ch.ready) begin
                seen.from_cyl = move_ch.move_from;
                seen.to_cyl   = move_ch.move_to;
                seen.distance = move_ch.move_distance;
                seen.total    = move_ch.running_total;
                seen.count    = move_ch.request_total;
                seen.fin      = move_ch.final_move;
                sb.check_move(seen);
            end
            move_ch.ready <= i_rst_n && (in_calm_window() || $urandom_range(0, 99) >= 7);
        end
    end

    task automatic send_request(input logic [CYL_W-1:0] cyl, input logic last);
        while (!in_calm_window() && $urandom_range(0, 99) < 7) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid            <= 1'b1;
        req_ch.request_cylinder <= cyl;
        req_ch.batch_end        <= last;
        do @(posedge i_clk); while (!req_ch.ready);
        sb.note_request(cyl, last);
        items_sent++;
    endtask

    task automatic drain(input int settle);
        req_ch.valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [CYL_W-1:0] end_val,
                                input logic [CYL_W-1:0] start_val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_END_CYL;
        i_cfg_data  <= end_val;
        @(posedge i_clk);
        sb.set_register(REG_END_CYL, end_val);
        i_cfg_index <= REG_START_POS;
        i_cfg_data  <= start_val;
        @(posedge i_clk);
        sb.set_register(REG_START_POS, start_val);
        i_cfg_we <= 1'b0;
        settings++;
    endtask

    function automatic logic [CYL_W-1:0] pick_cylinder();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return sb.start_pos;
            3: return sb.start_pos + CYL_W'($urandom_range(0, 6)) - CYL_W'(3);
            4: return sb.end_cyl;
            default: return CYL_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [CYL_W-1:0] pick_reg_value();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            default: return CYL_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic send_batch(input int n);
        for (int i = 0; i < n; i++) send_request(pick_cylinder(), i == n - 1);
    endtask

    initial begin
        int r;
        int n;
        i_rst_n                 <= 1'b0;
        i_cfg_we                <= 1'b0;
        i_cfg_index             <= REG_END_CYL;
        i_cfg_data              <= '0;
        req_ch.valid            <= 1'b0;
        req_ch.request_cylinder <= '0;
        req_ch.batch_end        <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: head at 0, sweep out to the last cylinder.
        send_request(16'd0, 1'b0);
        send_request(16'hFFFF, 1'b0);
        send_request(16'd300, 1'b1);
        send_request(16'd1234, 1'b1);
        drain(CFG_SETTLE);

        // The end cylinder lies below an upward request, with duplicates at the head.
        write_config(16'd40000, 16'd20000);
        send_request(16'd20000, 1'b0);
        send_request(16'd50000, 1'b0);
        send_request(16'd10, 1'b0);
        send_request(16'd19999, 1'b0);
        send_request(16'd20000, 1'b0);
        send_request(16'hFFFF, 1'b1);
        drain(CFG_SETTLE);

        // Registers change while a batch is half loaded.
        send_request(16'd100, 1'b0);
        send_request(16'd30000, 1'b0);
        drain(CFG_SETTLE);
        write_config(16'd0, 16'hFFFF);
        send_request(16'hFFFF, 1'b0);
        send_request(16'd5, 1'b1);
        drain(CFG_SETTLE);

        write_config(16'hFFFF, 16'hFFFF);
        send_request(16'd0, 1'b0);
        send_request(16'd32768, 1'b1);
        drain(CFG_SETTLE);
        write_config(16'd0, 16'd0);
        send_request(16'd0, 1'b1);

        while (items_sent < ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 85)      n = $urandom_range(1, 10);
            else if (r < 95) n = $urandom_range(20, MAX_REQ);
            else             n = $urandom_range(MAX_REQ + 1, MAX_REQ + 4);
            if ($urandom_range(0, 3) == 0) begin
                drain(CFG_SETTLE);
                write_config(pick_reg_value(), pick_reg_value());
            end
            send_batch(n);
        end

        drain(TAIL);
        $display("Covered %0d requests in %0d batches (%0d dropped on a full batch).",
                 sb.requests, sb.batches, sb.dropped);
        $display("Checked %0d moves under %0d register settings.", sb.moves_checked,
                 settings);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
